// File: rtl/core/hktc_pkg.sv
// Shared types and constants of the Hall key travel calibrator.
`default_nettype none

package hktc_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int CFG_BITS      = 12;
    localparam int LEVEL_BITS    = 16;
    localparam int TRAVEL_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int REQ_BITS      = 2;

    // Widths of the shared add and compare unit.
    localparam int ALU_A_BITS = LEVEL_BITS + 1;
    localparam int SUM_BITS   = ALU_A_BITS + 1;
    localparam int DIFF_BITS  = SUM_BITS + 1;

    localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_INIT   = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEF_REST = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEF_DOWN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADZONE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPAN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_TRV = 3'd4;

    localparam logic [CFG_BITS-1:0]    DEF_REST_RST = 12'd1800;
    localparam logic [CFG_BITS-1:0]    DEF_DOWN_RST = 12'd2600;
    localparam logic [CFG_BITS-1:0]    DEADZONE_RST = 12'd8;
    localparam logic [CFG_BITS-1:0]    MIN_SPAN_RST = 12'd200;
    localparam logic [TRAVEL_BITS-1:0] FULL_TRV_RST = 16'd400;

    localparam logic CAL_RST = ({1'b0, DEF_DOWN_RST} > ({1'b0, DEF_REST_RST}
                               + {1'b0, MIN_SPAN_RST}));

    localparam logic [LEVEL_BITS-1:0] LEVEL_CLEARED = 16'hFFFF;

    typedef struct packed {
        logic [REQ_BITS-1:0]    req_type;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   filter_ready;
    } in_item_t;

    typedef struct packed {
        logic [TRAVEL_BITS-1:0] distance;
        logic                   calibrated;
        logic [SAMPLE_BITS-1:0] last_value;
        logic [LEVEL_BITS-1:0]  rest_out;
        logic [LEVEL_BITS-1:0]  down_out;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/hall_key_travel_calibrator_top.sv
// Top level of the Hall key travel calibrator: level tracking and travel scaling.
//
// Usage: requests arrive on the in_* channel (sample, load defaults, clear) and each
// transfer produces exactly one result on the out_* channel. A transfer happens at a
// rising edge with valid high and stall low. in_stall is high while an item is being
// worked on; one item is in flight at a time.
// All arithmetic runs through one shared add-and-compare unit stepped by a small
// sequencer: deadzone checks, span check, clamping, span, then one 16x16 multiply
// and a restoring division that retires one quotient bit per cycle.
// Cycles from input transfer to result valid: clear or unused request 1, init 2,
// uncalibrated sample 1 to 4, calibrated sample 22 (filter not ready) or 25
// (filter ready). The next item may be taken one cycle after the result appears,
// so a calibrated sample costs up to 26 cycles; the 16-step division dominates.
// The result register holds its contents while out_stall is high; a new item can
// be accepted meanwhile, and its result waits in the last step until the register
// is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and must
// only be made while the block is idle. Reset loads the register defaults and the
// matching levels, clears the held sample and distance, and empties the output.
`default_nettype none

module hall_key_travel_calibrator_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire hktc_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output hktc_pkg::out_item_t                      out_data,
    input  wire logic                                cfg_we,
    input  wire logic [hktc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [hktc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REST,
        S_DOWN,
        S_SPAN,
        S_CLO,
        S_CHI,
        S_DIFF,
        S_SPANW,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    localparam logic [3:0] DIV_LAST = 4'(hktc_pkg::LEVEL_BITS - 1);

    state_t state_reg;

    logic [hktc_pkg::CFG_BITS-1:0]    def_rest_reg;
    logic [hktc_pkg::CFG_BITS-1:0]    def_down_reg;
    logic [hktc_pkg::CFG_BITS-1:0]    dz_reg;
    logic [hktc_pkg::CFG_BITS-1:0]    min_span_reg;
    logic [hktc_pkg::TRAVEL_BITS-1:0] ft_reg;

    logic [hktc_pkg::LEVEL_BITS-1:0]  rest_reg;
    logic [hktc_pkg::LEVEL_BITS-1:0]  down_reg;
    logic                             cal_reg;
    logic [hktc_pkg::SAMPLE_BITS-1:0] last_reg;
    logic [hktc_pkg::TRAVEL_BITS-1:0] travel_reg;
    logic                             is_sample_reg;

    logic [hktc_pkg::LEVEL_BITS-1:0]  vc_reg;
    logic [hktc_pkg::LEVEL_BITS-1:0]  d_reg;
    logic [hktc_pkg::LEVEL_BITS-1:0]  span_reg;
    logic [hktc_pkg::LEVEL_BITS-1:0]  rem_reg;
    logic [hktc_pkg::LEVEL_BITS-1:0]  quo_reg;
    logic [3:0]                       cnt_reg;

    logic                             out_valid_reg;
    hktc_pkg::out_item_t              out_data_reg;

    logic [hktc_pkg::ALU_A_BITS-1:0]  alu_a;
    logic [hktc_pkg::CFG_BITS-1:0]    alu_b;
    logic [hktc_pkg::LEVEL_BITS-1:0]  alu_c;
    logic [hktc_pkg::SUM_BITS-1:0]    alu_sum;
    logic [hktc_pkg::DIFF_BITS-1:0]   alu_diff;
    logic                             alu_lt;

    logic [hktc_pkg::LEVEL_BITS-1:0]  v16;
    logic [2*hktc_pkg::LEVEL_BITS-1:0] prod;
    logic [hktc_pkg::LEVEL_BITS-1:0]  quo_next;
    logic [hktc_pkg::LEVEL_BITS-1:0]  rem_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign v16  = {{(hktc_pkg::LEVEL_BITS-hktc_pkg::SAMPLE_BITS){1'b0}}, last_reg};
    assign prod = d_reg * ft_reg;

    // Shared unit: compares a + b against c and gives a + b - c.
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
        unique case (state_reg)
            S_REST:
            begin
                alu_a = {1'b0, v16};
                alu_b = dz_reg;
                alu_c = rest_reg;
            end
            S_DOWN:
            begin
                alu_a = {1'b0, down_reg};
                alu_b = dz_reg;
                alu_c = v16;
            end
            S_SPAN:
            begin
                alu_a = {1'b0, rest_reg};
                alu_b = min_span_reg;
                alu_c = down_reg;
            end
            S_CLO:
            begin
                alu_a = {1'b0, v16};
                alu_c = rest_reg;
            end
            S_CHI:
            begin
                alu_a = {1'b0, down_reg};
                alu_c = vc_reg;
            end
            S_DIFF:
            begin
                alu_a = {1'b0, vc_reg};
                alu_c = rest_reg;
            end
            S_SPANW:
            begin
                alu_a = {1'b0, down_reg};
                alu_c = rest_reg;
            end
            S_DIV:
            begin
                alu_a = {rem_reg, quo_reg[hktc_pkg::LEVEL_BITS-1]};
                alu_c = span_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign alu_sum  = {1'b0, alu_a}
                    + {{(hktc_pkg::SUM_BITS-hktc_pkg::CFG_BITS){1'b0}}, alu_b};
    assign alu_diff = {1'b0, alu_sum}
                    - {{(hktc_pkg::DIFF_BITS-hktc_pkg::LEVEL_BITS){1'b0}}, alu_c};
    assign alu_lt   = alu_diff[hktc_pkg::DIFF_BITS-1];

    // The partial remainder always stays below the span, so 16 bits hold it.
    assign rem_next = alu_lt ? alu_a[hktc_pkg::LEVEL_BITS-1:0]
                             : alu_diff[hktc_pkg::LEVEL_BITS-1:0];
    assign quo_next = {quo_reg[hktc_pkg::LEVEL_BITS-2:0], ~alu_lt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_rest_reg <= hktc_pkg::DEF_REST_RST;
            def_down_reg <= hktc_pkg::DEF_DOWN_RST;
            dz_reg       <= hktc_pkg::DEADZONE_RST;
            min_span_reg <= hktc_pkg::MIN_SPAN_RST;
            ft_reg       <= hktc_pkg::FULL_TRV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hktc_pkg::CFG_DEF_REST: def_rest_reg <= cfg_data[hktc_pkg::CFG_BITS-1:0];
                hktc_pkg::CFG_DEF_DOWN: def_down_reg <= cfg_data[hktc_pkg::CFG_BITS-1:0];
                hktc_pkg::CFG_DEADZONE: dz_reg       <= cfg_data[hktc_pkg::CFG_BITS-1:0];
                hktc_pkg::CFG_MIN_SPAN: min_span_reg <= cfg_data[hktc_pkg::CFG_BITS-1:0];
                hktc_pkg::CFG_FULL_TRV: ft_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rest_reg      <= {4'd0, hktc_pkg::DEF_REST_RST};
            down_reg      <= {4'd0, hktc_pkg::DEF_DOWN_RST};
            cal_reg       <= hktc_pkg::CAL_RST;
            last_reg      <= '0;
            travel_reg    <= '0;
            is_sample_reg <= 1'b0;
            vc_reg        <= '0;
            d_reg         <= '0;
            span_reg      <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // While the result register is free, it holds a result exactly when
            // the final step loads one.
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= (state_reg == S_FIN);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (in_data.req_type)
                            hktc_pkg::REQ_SAMPLE:
                            begin
                                last_reg      <= in_data.sample;
                                is_sample_reg <= 1'b1;
                                if (in_data.filter_ready)
                                begin
                                    state_reg <= S_REST;
                                end
                                else if (cal_reg)
                                begin
                                    state_reg <= S_CLO;
                                end
                                else
                                begin
                                    travel_reg <= '0;
                                    state_reg  <= S_FIN;
                                end
                            end
                            hktc_pkg::REQ_INIT:
                            begin
                                rest_reg      <= {4'd0, def_rest_reg};
                                down_reg      <= {4'd0, def_down_reg};
                                last_reg      <= '0;
                                travel_reg    <= '0;
                                is_sample_reg <= 1'b0;
                                state_reg     <= S_SPAN;
                            end
                            hktc_pkg::REQ_CLEAR:
                            begin
                                rest_reg  <= hktc_pkg::LEVEL_CLEARED;
                                down_reg  <= '0;
                                cal_reg   <= 1'b0;
                                state_reg <= S_FIN;
                            end
                            default:
                            begin
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_REST:
                begin
                    if (alu_lt)
                    begin
                        rest_reg <= v16;
                    end
                    state_reg <= S_DOWN;
                end
                S_DOWN:
                begin
                    if (alu_lt)
                    begin
                        down_reg <= v16;
                    end
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    cal_reg <= alu_lt;
                    if (alu_lt && is_sample_reg)
                    begin
                        state_reg <= S_CLO;
                    end
                    else
                    begin
                        travel_reg <= '0;
                        state_reg  <= S_FIN;
                    end
                end
                S_CLO:
                begin
                    vc_reg    <= alu_lt ? rest_reg : v16;
                    state_reg <= S_CHI;
                end
                S_CHI:
                begin
                    if (alu_lt)
                    begin
                        vc_reg <= down_reg;
                    end
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    d_reg     <= alu_diff[hktc_pkg::LEVEL_BITS-1:0];
                    state_reg <= S_SPANW;
                end
                S_SPANW:
                begin
                    span_reg <= alu_diff[hktc_pkg::LEVEL_BITS-1:0];
                    if (alu_diff[hktc_pkg::LEVEL_BITS-1:0] == '0)
                    begin
                        travel_reg <= '0;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    rem_reg   <= prod[2*hktc_pkg::LEVEL_BITS-1:hktc_pkg::LEVEL_BITS];
                    quo_reg   <= prod[hktc_pkg::LEVEL_BITS-1:0];
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        travel_reg <= quo_next;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_data_reg.distance   <= travel_reg;
                        out_data_reg.calibrated <= cal_reg;
                        out_data_reg.last_value <= last_reg;
                        out_data_reg.rest_out   <= rest_reg;
                        out_data_reg.down_out   <= down_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while the sequencer did not leave idle");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < span_reg))
        else $error("division remainder not below the span");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall) |=> (state_reg == S_FIN))
        else $error("result overwrote a stalled output");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result appeared outside the final step");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the Hall key travel calibrator top level.
`timescale 1ns / 100ps

module tb;

    localparam logic [hktc_pkg::REQ_BITS-1:0]     REQ_UNUSED    = 2'd3;
    localparam logic [hktc_pkg::CFG_IDX_BITS-1:0] CFG_NO_REG    = 3'd5;
    localparam int                                SETTLE_CYCLES = 30;
    localparam int                                HOLD_CYCLES   = 400;
    localparam int                                IDLE_PERCENT  = 13;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    hktc_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    hktc_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [hktc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [hktc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    // Own copy of the registers and of the calibration state.
    logic [hktc_pkg::CFG_BITS-1:0]    cfg_def_rest = hktc_pkg::DEF_REST_RST;
    logic [hktc_pkg::CFG_BITS-1:0]    cfg_def_down = hktc_pkg::DEF_DOWN_RST;
    logic [hktc_pkg::CFG_BITS-1:0]    cfg_deadzone = hktc_pkg::DEADZONE_RST;
    logic [hktc_pkg::CFG_BITS-1:0]    cfg_min_span = hktc_pkg::MIN_SPAN_RST;
    logic [hktc_pkg::TRAVEL_BITS-1:0] cfg_full_travel = hktc_pkg::FULL_TRV_RST;
    logic [hktc_pkg::LEVEL_BITS-1:0]  lvl_rest =
        hktc_pkg::LEVEL_BITS'(hktc_pkg::DEF_REST_RST);
    logic [hktc_pkg::LEVEL_BITS-1:0]  lvl_down =
        hktc_pkg::LEVEL_BITS'(hktc_pkg::DEF_DOWN_RST);
    logic                             key_cal = hktc_pkg::CAL_RST;
    logic [hktc_pkg::SAMPLE_BITS-1:0] held_sample = '0;
    logic [hktc_pkg::TRAVEL_BITS-1:0] held_travel = '0;

    hktc_pkg::out_item_t travel_reports_due[$];
    hktc_pkg::out_item_t due_head;

    int errors = 0;
    int requests_sent = 0;
    int reports_checked = 0;
    int settings_used = 1;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_start = 1'b0;
    int hold_count = 0;

    hall_key_travel_calibrator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic span_is_ok();
        int unsigned rest_v;
        int unsigned down_v;
        rest_v = lvl_rest;
        down_v = lvl_down;
        return down_v > rest_v + cfg_min_span;
    endfunction

    function automatic void predict_travel(input hktc_pkg::in_item_t req);
        hktc_pkg::out_item_t rpt;
        int unsigned v;
        int unsigned rest_v;
        int unsigned down_v;
        int unsigned span;
        v = req.sample;
        case (req.req_type)
            hktc_pkg::REQ_SAMPLE:
            begin
                held_sample = req.sample;
                if (req.filter_ready)
                begin
                    rest_v = lvl_rest;
                    down_v = lvl_down;
                    if (v + cfg_deadzone < rest_v)
                        lvl_rest = hktc_pkg::LEVEL_BITS'(v);
                    if (v > down_v + cfg_deadzone)
                        lvl_down = hktc_pkg::LEVEL_BITS'(v);
                    key_cal = span_is_ok();
                end
                held_travel = '0;
                if (key_cal)
                begin
                    rest_v = lvl_rest;
                    down_v = lvl_down;
                    if (v < rest_v)
                        v = rest_v;
                    if (v > down_v)
                        v = down_v;
                    span = down_v - rest_v;
                    if (span != 0)
                        held_travel = hktc_pkg::TRAVEL_BITS'(
                            ((v - rest_v) * cfg_full_travel) / span);
                end
            end
            hktc_pkg::REQ_INIT:
            begin
                lvl_rest = hktc_pkg::LEVEL_BITS'(cfg_def_rest);
                lvl_down = hktc_pkg::LEVEL_BITS'(cfg_def_down);
                key_cal = span_is_ok();
                held_sample = '0;
                held_travel = '0;
            end
            hktc_pkg::REQ_CLEAR:
            begin
                // The held sample and distance survive a clear.
                lvl_rest = hktc_pkg::LEVEL_CLEARED;
                lvl_down = '0;
                key_cal = 1'b0;
            end
            default:
            begin
            end
        endcase
        rpt.distance = held_travel;
        rpt.calibrated = key_cal;
        rpt.last_value = held_sample;
        rpt.rest_out = lvl_rest;
        rpt.down_out = lvl_down;
        travel_reports_due.push_back(rpt);
    endfunction

    function automatic hktc_pkg::in_item_t make_req(
        input logic [hktc_pkg::REQ_BITS-1:0] kind,
        input logic [hktc_pkg::SAMPLE_BITS-1:0] value,
        input logic ready);
        hktc_pkg::in_item_t req;
        req.req_type = kind;
        req.sample = value;
        req.filter_ready = ready;
        return req;
    endfunction

    // Mostly key strokes between and slightly beyond the current levels, with
    // the odd load, clear, unused code and wild sample mixed in.
    function automatic hktc_pkg::in_item_t random_request();
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        logic [hktc_pkg::SAMPLE_BITS-1:0] value;
        logic ready;
        pick = $urandom_range(99);
        value = hktc_pkg::SAMPLE_BITS'($urandom);
        ready = $urandom_range(99) < 85;
        if (pick < 3)
            return make_req(hktc_pkg::REQ_CLEAR, value, ready);
        if (pick < 6)
            return make_req(hktc_pkg::REQ_INIT, value, ready);
        if (pick < 8)
            return make_req(REQ_UNUSED, value, ready);
        if (lvl_rest <= lvl_down && lvl_down <= 4095 && $urandom_range(99) < 75)
        begin
            lo = (lvl_rest > 64) ? lvl_rest - 64 : 0;
            hi = (lvl_down + 64 > 4095) ? 4095 : lvl_down + 64;
            value = hktc_pkg::SAMPLE_BITS'($urandom_range(hi, lo));
        end
        return make_req(hktc_pkg::REQ_SAMPLE, value, ready);
    endfunction

    // Receiver: random stalls, or a long hold-off once it has been triggered.
    always @(posedge clk)
    begin
        if (hold_count != 0)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count - 1;
        end
        else if (hold_start)
        begin
            out_stall <= 1'b1;
            hold_count <= HOLD_CYCLES;
        end
        else
            out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (travel_reports_due.size() == 0)
                report_mismatch("result transfer with nothing outstanding");
            else
            begin
                due_head = travel_reports_due.pop_front();
                reports_checked++;
                if (out_data.distance !== due_head.distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              out_data.distance, due_head.distance));
                if (out_data.calibrated !== due_head.calibrated)
                    report_mismatch($sformatf("calibrated %0b, expected %0b",
                                              out_data.calibrated, due_head.calibrated));
                if (out_data.last_value !== due_head.last_value)
                    report_mismatch($sformatf("last_value %0d, expected %0d",
                                              out_data.last_value, due_head.last_value));
                if (out_data.rest_out !== due_head.rest_out)
                    report_mismatch($sformatf("rest_out %0d, expected %0d",
                                              out_data.rest_out, due_head.rest_out));
                if (out_data.down_out !== due_head.down_out)
                    report_mismatch($sformatf("down_out %0d, expected %0d",
                                              out_data.down_out, due_head.down_out));
            end
        end
    end

    // Valid stays high from one transfer to the next unless a gap is taken.
    task automatic send_request(input hktc_pkg::in_item_t req);
        if (tx_idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(30, 4)) @(posedge clk);
            else
                repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_travel(req);
        requests_sent++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (travel_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic put_reg(input logic [hktc_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [hktc_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            hktc_pkg::CFG_DEF_REST: cfg_def_rest = value[hktc_pkg::CFG_BITS-1:0];
            hktc_pkg::CFG_DEF_DOWN: cfg_def_down = value[hktc_pkg::CFG_BITS-1:0];
            hktc_pkg::CFG_DEADZONE: cfg_deadzone = value[hktc_pkg::CFG_BITS-1:0];
            hktc_pkg::CFG_MIN_SPAN: cfg_min_span = value[hktc_pkg::CFG_BITS-1:0];
            hktc_pkg::CFG_FULL_TRV: cfg_full_travel = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic write_settings(input logic [hktc_pkg::CFG_BITS-1:0] rest_def,
                                  input logic [hktc_pkg::CFG_BITS-1:0] down_def,
                                  input logic [hktc_pkg::CFG_BITS-1:0] deadzone,
                                  input logic [hktc_pkg::CFG_BITS-1:0] span,
                                  input logic [hktc_pkg::TRAVEL_BITS-1:0] travel);
        put_reg(hktc_pkg::CFG_DEF_REST, hktc_pkg::CFG_DATA_BITS'(rest_def));
        put_reg(hktc_pkg::CFG_DEF_DOWN, hktc_pkg::CFG_DATA_BITS'(down_def));
        put_reg(hktc_pkg::CFG_DEADZONE, hktc_pkg::CFG_DATA_BITS'(deadzone));
        put_reg(hktc_pkg::CFG_MIN_SPAN, hktc_pkg::CFG_DATA_BITS'(span));
        put_reg(hktc_pkg::CFG_FULL_TRV, travel);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic test_directed_requests();
        send_request(make_req(REQ_UNUSED, 12'hFFF, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd2200, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd0, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'hFFF, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'hAAA, 1'b0));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'h555, 1'b1));
        send_request(make_req(hktc_pkg::REQ_CLEAR, 12'hFFF, 1'b1));
        // Uncalibrated after the clear, so the distance reads zero.
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd2000, 1'b0));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd2000, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd2300, 1'b1));
        send_request(make_req(hktc_pkg::REQ_CLEAR, 12'd0, 1'b0));
        send_request(make_req(hktc_pkg::REQ_INIT, 12'hFFF, 1'b1));
        send_request(make_req(REQ_UNUSED, 12'd0, 1'b0));
    endtask

    task automatic test_register_extremes();
        wait_quiet();
        write_settings(12'd0, 12'hFFF, 12'd0, 12'd0, 16'hFFFF);
        send_request(make_req(hktc_pkg::REQ_INIT, 12'd0, 1'b0));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'hFFF, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd1, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd2048, 1'b0));
        wait_quiet();
        // Defaults upside down and the widest deadzone: nothing can calibrate.
        put_reg(CFG_NO_REG, 16'h0123);
        write_settings(12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 16'd1);
        send_request(make_req(hktc_pkg::REQ_INIT, 12'd0, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'hFFF, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd0, 1'b1));
        wait_quiet();
        // Equal levels give a zero span until the bottom-out level moves.
        write_settings(12'd1000, 12'd1000, 12'd0, 12'd0, 16'd400);
        send_request(make_req(hktc_pkg::REQ_INIT, 12'd0, 1'b0));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd1000, 1'b1));
        send_request(make_req(hktc_pkg::REQ_SAMPLE, 12'd1001, 1'b1));
    endtask

    task automatic write_random_settings();
        logic [hktc_pkg::CFG_BITS-1:0] rest_def;
        logic [hktc_pkg::CFG_BITS-1:0] down_def;
        logic [hktc_pkg::CFG_BITS-1:0] deadzone;
        logic [hktc_pkg::CFG_BITS-1:0] span;
        logic [hktc_pkg::TRAVEL_BITS-1:0] travel;
        rest_def = hktc_pkg::CFG_BITS'($urandom_range(2000, 0));
        if ($urandom_range(99) < 80)
            down_def = hktc_pkg::CFG_BITS'($urandom_range(4095, rest_def));
        else
            down_def = hktc_pkg::CFG_BITS'($urandom);
        deadzone = ($urandom_range(9) == 0) ? hktc_pkg::CFG_BITS'($urandom)
                                            : hktc_pkg::CFG_BITS'($urandom_range(40, 0));
        span = ($urandom_range(9) == 0) ? hktc_pkg::CFG_BITS'($urandom)
                                        : hktc_pkg::CFG_BITS'($urandom_range(400, 0));
        case ($urandom_range(9))
            0: travel = 16'd1;
            1: travel = 16'hFFFF;
            2: travel = hktc_pkg::TRAVEL_BITS'($urandom_range(65535, 1));
            default: travel = hktc_pkg::TRAVEL_BITS'($urandom_range(1000, 1));
        endcase
        write_settings(rest_def, down_def, deadzone, span, travel);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            wait_quiet();
            write_random_settings();
            send_request(make_req(hktc_pkg::REQ_INIT,
                                  hktc_pkg::SAMPLE_BITS'($urandom), 1'b1));
            for (int n = 1; n < per_phase; n++)
                send_request(random_request());
        end
    endtask

    task automatic test_no_idling(input int count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int n = 0; n < count; n++)
            send_request(random_request());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its input.
    task automatic test_receiver_hold(input int count);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (int n = 0; n < count; n++)
            send_request(random_request());
    endtask

    task automatic test_sender_pauses(input int rounds, input int per_round);
        for (int r = 0; r < rounds; r++)
        begin
            for (int n = 0; n < per_round; n++)
                send_request(random_request());
            wait_quiet();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_requests();
        test_register_extremes();
        wait_quiet();
        write_settings(hktc_pkg::DEF_REST_RST, hktc_pkg::DEF_DOWN_RST,
                       hktc_pkg::DEADZONE_RST, hktc_pkg::MIN_SPAN_RST,
                       hktc_pkg::FULL_TRV_RST);
        test_receiver_hold(40);
        test_random_phases(6, 230);
        test_no_idling(300);
        test_sender_pauses(4, 25);
        wait_quiet();
        if (travel_reports_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", travel_reports_due.size()));
        $display("Run covered %0d requests (samples, default loads, clears, unused codes)",
                 requests_sent);
        $display("under %0d register settings; %0d results compared, %0d mismatches.",
                 settings_used, reports_checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
